/* sv/quaternion_rotation_unit_defines.svh */
// Assertion macros shared by the quaternion rotation unit.
// Expects clk and arst_n in the scope of each use.
`ifndef QUATERNION_ROTATION_UNIT_DEFINES_SVH
`define QUATERNION_ROTATION_UNIT_DEFINES_SVH

// same-cycle implication
`define QRU_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quaternion rotation unit: check failed");

// next-cycle implication
`define QRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quaternion rotation unit: check failed");

`endif

/* sv/qru_pkg.sv */
// Types and constants of the quaternion rotation unit.
// No dependencies.
package qru_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// operands are one bit wider so that negating the most negative value is exact
	localparam int OPND_W = COMP_WIDTH + 1;
	localparam int PROD_W = 2 * OPND_W;
	// four products plus the rounding half
	localparam int SUM_W  = PROD_W + 3;

	localparam int IN_DATA_W  = 8 * COMP_WIDTH;
	localparam int OUT_DATA_W = ((4 * COMP_WIDTH + 7) / 8) * 8;

	localparam logic signed [SUM_W-1:0] CMAX =
		SUM_W'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;
	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [1:0] {
		REQ_PROD = 2'd0,
		REQ_SAND = 2'd1,
		REQ_ROT  = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef logic [3:0][COMP_WIDTH-1:0] quat_t;
	typedef logic [3:0][OPND_W-1:0]     opnd_t;
	typedef logic [15:0][PROD_W-1:0]    prod_t;

	// travels alongside the data through every stage
	typedef struct packed {
		req_t  mode;
		quat_t a;
		quat_t t;
		logic  sat1;
	} side_t;

endpackage

/* sv/qru_prod.sv */
// Partial-product stage: all sixteen products x[i]*y[j] of two quaternions.
// Depends on qru_pkg.
module qru_prod (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qru_pkg::opnd_t  x,
	input  qru_pkg::opnd_t  y,
	input  qru_pkg::side_t  side_in,
	output logic            out_valid,
	input  logic            out_ready,
	output qru_pkg::prod_t  prod,
	output qru_pkg::side_t  side_out
);
	import qru_pkg::*;

	logic  vld_q;
	prod_t prod_d;
	prod_t prod_s1;
	side_t side_s1;

	assign in_ready = !vld_q || out_ready;

	// index 4*i+j holds x[i]*y[j]
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_d[4*i+j] = $signed(x[i]) * $signed(y[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s1 <= prod_d;
			side_s1 <= side_in;
		end
	end

	assign out_valid = vld_q;
	assign prod      = prod_s1;
	assign side_out  = side_s1;

endmodule

/* sv/qru_fin.sv */
// Sum stage: Hamilton-product sums of four products, round half up, saturate.
// Depends on qru_pkg.
module qru_fin (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qru_pkg::prod_t  prod,
	input  qru_pkg::side_t  side_in,
	output logic            out_valid,
	input  logic            out_ready,
	output qru_pkg::quat_t  res,
	output logic [3:0]      sat,
	output qru_pkg::side_t  side_out
);
	import qru_pkg::*;

	logic                      vld_q;
	logic signed [SUM_W-1:0]   sx [16];
	logic signed [SUM_W-1:0]   sum [4];
	logic signed [SUM_W-1:0]   shr [4];
	quat_t                     res_d;
	logic [3:0]                sat_d;
	quat_t                     res_s2;
	logic [3:0]                sat_s2;
	side_t                     side_s2;

	assign in_ready = !vld_q || out_ready;

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			sx[k] = {{(SUM_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
		end
		// w: a0b0 - a1b1 - a2b2 - a3b3, then the i, j, k parts
		sum[0] = RND_HALF + sx[0] - sx[5]  - sx[10] - sx[15];
		sum[1] = RND_HALF + sx[1] + sx[4]  + sx[11] - sx[14];
		sum[2] = RND_HALF + sx[2] - sx[7]  + sx[8]  + sx[13];
		sum[3] = RND_HALF + sx[3] + sx[6]  - sx[9]  + sx[12];
		for (int c = 0; c < 4; c++) begin
			shr[c] = sum[c] >>> FRAC_BITS;
			if (shr[c] > CMAX) begin
				res_d[c] = CMAX[COMP_WIDTH-1:0];
				sat_d[c] = 1'b1;
			end else if (shr[c] < CMIN) begin
				res_d[c] = CMIN[COMP_WIDTH-1:0];
				sat_d[c] = 1'b1;
			end else begin
				res_d[c] = shr[c][COMP_WIDTH-1:0];
				sat_d[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s2  <= res_d;
			sat_s2  <= sat_d;
			side_s2 <= side_in;
		end
	end

	assign out_valid = vld_q;
	assign res       = res_s2;
	assign sat       = sat_s2;
	assign side_out  = side_s2;

endmodule

/* sv/quaternion_rotation_unit.sv */
// Quaternion rotation unit: A*B, A*B*conj(A), or rotation of vector B by A.
// Five register stages (two product, two sum/round, one output) lie between the input
// transfer and m_tvalid. Throughput: one item per cycle unless m_tready stalls the output.
// A stall reaches s_tready combinationally through every stage; bubbles are squeezed out.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
// Depends on qru_pkg, qru_prod, qru_fin and quaternion_rotation_unit_defines.svh.
`include "quaternion_rotation_unit_defines.svh"

module quaternion_rotation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from bit 0 up
	input  logic [qru_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// r_w, r_x, r_y, r_z from bit 0 up, zero padded
	output logic [qru_pkg::OUT_DATA_W-1:0]    m_tdata,
	// saturated
	output logic                              m_tuser
);
	import qru_pkg::*;

	opnd_t      x1, y1, x2, y2;
	side_t      side1, side2;
	quat_t      a_in, b_in;
	req_t       req;

	logic       p1_vld, p1_rdy, f1_vld, f1_rdy, p2_vld, p2_rdy, f2_vld, f2_rdy;
	prod_t      p1_prod, p2_prod;
	side_t      p1_side, f1_side, p2_side, f2_side;
	quat_t      f1_res, f2_res;
	logic [3:0] f1_sat, f2_sat;

	quat_t      res_d;
	logic       sat_d;
	logic       vld_q;
	quat_t      res_s5;
	logic       sat_s5;
	req_t       mode_s5;

	assign req = req_t'(s_tuser);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_in[i] = s_tdata[i*COMP_WIDTH +: COMP_WIDTH];
			b_in[i] = s_tdata[(i+4)*COMP_WIDTH +: COMP_WIDTH];
			x1[i]   = {a_in[i][COMP_WIDTH-1], a_in[i]};
			y1[i]   = {b_in[i][COMP_WIDTH-1], b_in[i]};
		end
		// pure vector for rotation
		if (req == REQ_ROT) begin
			y1[0] = '0;
		end
		side1.mode = req;
		side1.a    = a_in;
		side1.t    = '0;
		side1.sat1 = 1'b0;
	end

	qru_prod u_prod1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.x(x1), .y(y1), .side_in(side1),
		.out_valid(p1_vld), .out_ready(p1_rdy),
		.prod(p1_prod), .side_out(p1_side)
	);

	qru_fin u_fin1 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(p1_vld), .in_ready(p1_rdy),
		.prod(p1_prod), .side_in(p1_side),
		.out_valid(f1_vld), .out_ready(f1_rdy),
		.res(f1_res), .sat(f1_sat), .side_out(f1_side)
	);

	// second product: t * conj(A), conj formed one bit wider
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			x2[i] = {f1_res[i][COMP_WIDTH-1], f1_res[i]};
			if (i == 0) begin
				y2[i] = {f1_side.a[i][COMP_WIDTH-1], f1_side.a[i]};
			end else begin
				y2[i] = OPND_W'(-$signed({f1_side.a[i][COMP_WIDTH-1], f1_side.a[i]}));
			end
		end
		side2      = f1_side;
		side2.t    = f1_res;
		side2.sat1 = |f1_sat;
	end

	qru_prod u_prod2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f1_vld), .in_ready(f1_rdy),
		.x(x2), .y(y2), .side_in(side2),
		.out_valid(p2_vld), .out_ready(p2_rdy),
		.prod(p2_prod), .side_out(p2_side)
	);

	qru_fin u_fin2 (
		.clk(clk), .arst_n(arst_n),
		.in_valid(p2_vld), .in_ready(p2_rdy),
		.prod(p2_prod), .side_in(p2_side),
		.out_valid(f2_vld), .out_ready(f2_rdy),
		.res(f2_res), .sat(f2_sat), .side_out(f2_side)
	);

	// result select per request kind
	always_comb begin
		case (f2_side.mode)
			REQ_PROD: begin
				res_d = f2_side.t;
				sat_d = f2_side.sat1;
			end
			REQ_SAND: begin
				res_d = f2_res;
				sat_d = f2_side.sat1 | (|f2_sat);
			end
			REQ_ROT: begin
				res_d    = f2_res;
				res_d[0] = '0;
				sat_d    = f2_side.sat1 | (|f2_sat[3:1]);
			end
			default: begin
				res_d = '0;
				sat_d = 1'b0;
			end
		endcase
	end

	assign f2_rdy = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (f2_rdy) begin
			vld_q <= f2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (f2_rdy && f2_vld) begin
			res_s5  <= res_d;
			sat_s5  <= sat_d;
			mode_s5 <= f2_side.mode;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = OUT_DATA_W'(res_s5);
	assign m_tuser  = sat_s5;

	`QRU_ASSERT(a_rot_scalar_zero, vld_q && mode_s5 == REQ_ROT, res_s5[0] == '0)
	`QRU_ASSERT(a_unused_req_zero, vld_q && mode_s5 == REQ_NONE, res_s5 == '0 && !sat_s5)
	`QRU_ASSERT_NEXT(a_fin2_holds, f2_vld && !f2_rdy, f2_vld && $stable(f2_res))

endmodule
